// ===== hdl/svp_pkg.sv =====
// shared widths, codes, constants and beat types of the segment velocity profiler
package svp_pkg;

   localparam int COORD_BITS     = 16;
   localparam int DIST_FRAC_BITS = 8;

   // register field widths
   localparam int ACC_W  = 12;
   localparam int SEG_W  = 16;
   localparam int GAIN_W = 10;
   localparam int OFF_W  = 10;
   localparam int SPD_W  = 12;
   localparam int HEAD_W = 9;
   localparam int STEP_W = 9;
   localparam int LINE_W = 2;
   localparam int PH_W   = 2;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = SEG_W;

   localparam logic [CSR_IDX_W-1:0] REG_ACCEL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEGLEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TURNSPD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STEP   = 3'd6;

   localparam logic [ACC_W-1:0]  RST_ACCEL   = 12'd300;
   localparam logic [SEG_W-1:0]  RST_SEGLEN  = 16'd890;
   localparam logic [GAIN_W-1:0] RST_GAIN    = 10'd100;
   localparam logic [OFF_W-1:0]  RST_OFFSET  = 10'd20;
   localparam logic [SPD_W-1:0]  RST_CRUISE  = 12'd220;
   localparam logic [SPD_W-1:0]  RST_TURNSPD = 12'd100;
   localparam logic [STEP_W-1:0] RST_STEP    = 9'd90;

   // phase and line codes
   localparam logic [PH_W-1:0] PH_ACCEL  = 2'd0;
   localparam logic [PH_W-1:0] PH_CRUISE = 2'd1;
   localparam logic [PH_W-1:0] PH_DECEL  = 2'd2;
   localparam logic [PH_W-1:0] PH_TURN   = 2'd3;

   localparam logic [LINE_W-1:0] LINE_SEEN  = 2'd0;
   localparam logic [LINE_W-1:0] LINE_NONE  = 2'd1;
   localparam logic [LINE_W-1:0] LINE_AMBIG = 2'd2;

   localparam logic MODE_TRACK = 1'b0;
   localparam logic MODE_TURN  = 1'b1;

   localparam logic [SPD_W-1:0]  SPEED_MAX = {SPD_W{1'b1}};
   localparam logic [HEAD_W:0]   DEG_FULL  = 10'd360;
   localparam logic [HEAD_W:0]   DEG_TWICE = 10'd720;

   // derived datapath widths
   localparam int MAG_W     = COORD_BITS + 1;
   localparam int D2_W      = 2 * MAG_W;
   localparam int SQ_IN_W   = D2_W + 2 * DIST_FRAC_BITS;
   localparam int SQ_OUT_W  = SQ_IN_W / 2;
   localparam int T_W       = SEG_W + DIST_FRAC_BITS;
   localparam int NUM_W     = T_W + 2 + DIST_FRAC_BITS;
   localparam int R_W       = (NUM_W + 1) / 2;
   localparam int MUL_W0    = (MAG_W > R_W) ? MAG_W : R_W;
   localparam int MUL_W1    = (MUL_W0 > SEG_W) ? MUL_W0 : SEG_W;
   localparam int MUL_W     = (MUL_W1 > GAIN_W) ? MUL_W1 : GAIN_W;
   localparam int P_W       = 2 * MUL_W;
   localparam int SQ_CNT_W  = $clog2(SQ_OUT_W + 1);
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   typedef struct packed {
      logic                         sample_ok;
      logic signed [COORD_BITS-1:0] pos_x_mm;
      logic signed [COORD_BITS-1:0] pos_y_mm;
      logic [LINE_W-1:0]            line_status;
   } svp_req_type;

   typedef struct packed {
      logic              drive_mode;
      logic [HEAD_W-1:0] heading_deg;
      logic [SPD_W-1:0]  speed_cmd;
      logic [PH_W-1:0]   phase;
   } svp_rsp_type;

endpackage

// ===== hdl/svp_mul.sv =====
// shared unsigned multiplier with registered product
module svp_mul (
   input  logic                     clock,
   input  logic [svp_pkg::MUL_W-1:0] a,
   input  logic [svp_pkg::MUL_W-1:0] b,
   output logic [svp_pkg::P_W-1:0]   p
);
   import svp_pkg::*;

   logic [P_W-1:0] p_ff;
   logic [P_W-1:0] p_in;

   assign p_in = P_W'(a) * P_W'(b);
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// ===== hdl/svp_isqrt.sv =====
// iterative integer square root, one result bit per cycle
module svp_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [svp_pkg::SQ_IN_W-1:0]  operand,
   output logic                        done,
   output logic [svp_pkg::SQ_OUT_W-1:0] root
);
   import svp_pkg::*;

   logic [SQ_IN_W-1:0]  val_ff;
   logic [SQ_OUT_W+1:0] rem_ff;
   logic [SQ_OUT_W-1:0] root_ff;
   logic [SQ_CNT_W-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [SQ_OUT_W+1:0] rem_sh;
   logic [SQ_OUT_W+1:0] trial;
   logic                fits;

   // bring down the next two bits and try root*4+1
   assign rem_sh = {rem_ff[SQ_OUT_W-1:0], val_ff[SQ_IN_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   assign done = done_ff;
   assign root = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            val_ff  <= operand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= SQ_CNT_W'(SQ_OUT_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            val_ff  <= val_ff << 2;
            rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
            root_ff <= {root_ff[SQ_OUT_W-2:0], fits};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == SQ_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== hdl/svp_div.sv =====
// restoring divider for the ramp quotient, one quotient bit per cycle
module svp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [svp_pkg::NUM_W-1:0] num,
   input  logic [svp_pkg::ACC_W-1:0] den,
   output logic                      done,
   output logic [svp_pkg::NUM_W-1:0] quo
);
   import svp_pkg::*;

   logic [NUM_W-1:0]     quo_ff;
   logic [ACC_W-1:0]     rem_ff;
   logic [ACC_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [ACC_W:0] rs;
   logic [ACC_W:0] sub;
   logic           ge;

   assign rs  = {rem_ff, quo_ff[NUM_W-1]};
   assign sub = rs - {1'b0, den_ff};
   assign ge  = (rs >= {1'b0, den_ff});

   assign done = done_ff;
   assign quo  = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= num;
            rem_ff  <= '0;
            den_ff  <= den;
            cnt_ff  <= DIV_CNT_W'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            rem_ff <= ge ? sub[ACC_W-1:0] : rs[ACC_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== hdl/segment_velocity_profiler.sv =====
// top level: sequencer, state and configuration of the segment velocity profiler
//
// Takes one odometry beat on req_* (position, line status, sample_ok) and gives
// one drive command beat on rsp_* for each beat with sample_ok set; a beat with
// sample_ok clear is taken and dropped, so such beats can be taken every cycle.
// req_stall is high while a sample is being worked on: one sample at a time passes
// through a shared multiplier, a bit-serial square root and a bit-serial divider
// under a small sequencer.
// Cruise, turn and overshoot samples go from acceptance through distance set-up
// and phase selection straight to the output register; ramp samples also pass
// through two square roots and one division, then gain scaling, before that.
// The sequencer returns to idle as the result is loaded and rsp_valid rises, so
// the next sample can be taken as soon as rsp_valid is high; one sample at a time
// is worked on.
// The result sits in an output register; a new sample is taken while it waits,
// and a finished result that finds the register still stalled holds until
// rsp_stall drops.
// csr_we writes register csr_index from csr_wdata; write only while idle.
// Synchronous reset loads the register defaults, puts the turn point at the
// origin with heading zero and empties the output register.
module segment_velocity_profiler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  svp_pkg::svp_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output svp_pkg::svp_rsp_type           rsp_data,
   input  logic                           csr_we,
   input  logic [svp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [svp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import svp_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF  = 4'd1;
   localparam logic [3:0] S_MDX   = 4'd2;
   localparam logic [3:0] S_MDY   = 4'd3;
   localparam logic [3:0] S_MACC  = 4'd4;
   localparam logic [3:0] S_MLEN  = 4'd5;
   localparam logic [3:0] S_MDIFF = 4'd6;
   localparam logic [3:0] S_CLASS = 4'd7;
   localparam logic [3:0] S_SQ1   = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_SQ2   = 4'd10;
   localparam logic [3:0] S_MGAIN = 4'd11;
   localparam logic [3:0] S_SPEED = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   // configuration
   logic [ACC_W-1:0]  accel_ff;
   logic [SEG_W-1:0]  seglen_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [OFF_W-1:0]  offset_ff;
   logic [SPD_W-1:0]  cruise_ff;
   logic [SPD_W-1:0]  turnspd_ff;
   logic [STEP_W-1:0] step_ff;

   // profile state
   logic signed [COORD_BITS-1:0] tpx_ff;
   logic signed [COORD_BITS-1:0] tpy_ff;
   logic [HEAD_W-1:0]            heading_ff;

   // sample working registers
   logic [3:0]                   state_ff;
   logic [3:0]                   state_in;
   logic signed [COORD_BITS-1:0] x_ff;
   logic signed [COORD_BITS-1:0] y_ff;
   logic [LINE_W-1:0]            ls_ff;
   logic [MAG_W-1:0]             dx_ff;
   logic [MAG_W-1:0]             dy_ff;
   logic [P_W-1:0]               d2_ff;
   logic [P_W-1:0]               acc2_ff;
   logic [P_W-1:0]               len2_ff;
   logic [PH_W-1:0]              ph_ff;
   svp_rsp_type                  res_ff;

   logic        rsp_valid_ff;
   svp_rsp_type rsp_data_ff;

   // shared units
   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [P_W-1:0]      mul_p;
   logic                sq_start;
   logic [SQ_IN_W-1:0]  sq_operand;
   logic                sq_done;
   logic [SQ_OUT_W-1:0] sq_root;
   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   logic [ACC_W-1:0]    div_den;
   logic                div_done;
   logic [NUM_W-1:0]    div_quo;

   // combinational helpers
   logic                    req_accept;
   logic signed [MAG_W-1:0] dx_s;
   logic signed [MAG_W-1:0] dy_s;
   logic signed [SEG_W:0]   diff_s;
   logic                    lt_acc;
   logic                    gt_diff;
   logic                    ge_len;
   logic                    lost;
   logic [PH_W-1:0]         ph_sel;
   logic [HEAD_W:0]         head_sum;
   logic [HEAD_W-1:0]       head_next;
   logic [T_W-1:0]          dfx;
   logic [T_W-1:0]          lfx;
   logic [T_W-1:0]          ramp_t;
   logic [P_W-DIST_FRAC_BITS:0] spd_sum;
   logic [SPD_W-1:0]        spd_sat;
   logic                    out_load;

   svp_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   svp_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .done    (sq_done),
      .root    (sq_root)
   );

   svp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // distance components as magnitudes
   assign dx_s = MAG_W'(x_ff) - MAG_W'(tpx_ff);
   assign dy_s = MAG_W'(y_ff) - MAG_W'(tpy_ff);
   assign diff_s = $signed({1'b0, seglen_ff}) - $signed((SEG_W + 1)'(accel_ff));

   // phase selection, squared distances compared exactly
   assign lt_acc  = (d2_ff < acc2_ff);
   assign gt_diff = diff_s[SEG_W] || (d2_ff > mul_p);
   assign ge_len  = (d2_ff >= len2_ff);
   assign lost    = (ls_ff == LINE_NONE) || (ls_ff == LINE_AMBIG);
   always_comb begin
      if (ge_len && lost) begin
         ph_sel = PH_TURN;
      end else if (lt_acc) begin
         ph_sel = PH_ACCEL;
      end else if (gt_diff) begin
         ph_sel = PH_DECEL;
      end else begin
         ph_sel = PH_CRUISE;
      end
   end

   // heading + step modulo 360, the sum stays below twice 360 plus a step
   assign head_sum = (HEAD_W + 1)'(heading_ff) + (HEAD_W + 1)'(step_ff);
   always_comb begin
      if (head_sum >= DEG_TWICE) begin
         head_next = HEAD_W'(head_sum - DEG_TWICE);
      end else if (head_sum >= DEG_FULL) begin
         head_next = HEAD_W'(head_sum - DEG_FULL);
      end else begin
         head_next = HEAD_W'(head_sum);
      end
   end

   // ramp operand: fixed-point distance or distance left in the segment
   assign dfx    = T_W'(sq_root);
   assign lfx    = T_W'(seglen_ff) << DIST_FRAC_BITS;
   assign ramp_t = (ph_ff == PH_ACCEL) ? dfx : (lfx - dfx);

   assign sq_start   = (state_ff == S_CLASS && ph_sel != PH_TURN && ph_sel != PH_CRUISE
                        && !ge_len) || (state_ff == S_DIV && div_done);
   assign sq_operand = (state_ff == S_CLASS) ?
                       (SQ_IN_W'(d2_ff[D2_W-1:0]) << (2 * DIST_FRAC_BITS)) :
                       SQ_IN_W'(div_quo);

   assign div_start = (state_ff == S_SQ1) && sq_done;
   assign div_num   = NUM_W'(ramp_t) << (DIST_FRAC_BITS + 2);
   assign div_den   = (accel_ff == '0) ? ACC_W'(1) : accel_ff;

   // multiplier operands by step
   always_comb begin
      case (state_ff)
         S_MDX: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(dx_ff);
         end
         S_MDY: begin
            mul_a = MUL_W'(dy_ff);
            mul_b = MUL_W'(dy_ff);
         end
         S_MACC: begin
            mul_a = MUL_W'(accel_ff);
            mul_b = MUL_W'(accel_ff);
         end
         S_MLEN: begin
            mul_a = MUL_W'(seglen_ff);
            mul_b = MUL_W'(seglen_ff);
         end
         S_MDIFF: begin
            mul_a = MUL_W'(diff_s[SEG_W-1:0]);
            mul_b = MUL_W'(diff_s[SEG_W-1:0]);
         end
         S_MGAIN: begin
            mul_a = MUL_W'(gain_ff);
            mul_b = MUL_W'(sq_root[R_W-1:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // gain * root scaled down, offset on acceleration, saturated
   always_comb begin
      spd_sum = (P_W - DIST_FRAC_BITS + 1)'(mul_p >> DIST_FRAC_BITS);
      if (ph_ff == PH_ACCEL) begin
         spd_sum = spd_sum + (P_W - DIST_FRAC_BITS + 1)'(offset_ff);
      end
      if (spd_sum > (P_W - DIST_FRAC_BITS + 1)'(SPEED_MAX)) begin
         spd_sat = SPEED_MAX;
      end else begin
         spd_sat = spd_sum[SPD_W-1:0];
      end
   end

   assign out_load = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_data.sample_ok) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF:  state_in = S_MDX;
         S_MDX:   state_in = S_MDY;
         S_MDY:   state_in = S_MACC;
         S_MACC:  state_in = S_MLEN;
         S_MLEN:  state_in = S_MDIFF;
         S_MDIFF: state_in = S_CLASS;
         S_CLASS: begin
            if (sq_start) begin
               state_in = S_SQ1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SQ1: begin
            if (sq_done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_SQ2;
            end
         end
         S_SQ2: begin
            if (sq_done) begin
               state_in = S_MGAIN;
            end
         end
         S_MGAIN: state_in = S_SPEED;
         S_SPEED: state_in = S_FIN;
         S_FIN: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff   <= RST_ACCEL;
         seglen_ff  <= RST_SEGLEN;
         gain_ff    <= RST_GAIN;
         offset_ff  <= RST_OFFSET;
         cruise_ff  <= RST_CRUISE;
         turnspd_ff <= RST_TURNSPD;
         step_ff    <= RST_STEP;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACCEL:   accel_ff   <= csr_wdata[ACC_W-1:0];
            REG_SEGLEN:  seglen_ff  <= csr_wdata[SEG_W-1:0];
            REG_GAIN:    gain_ff    <= csr_wdata[GAIN_W-1:0];
            REG_OFFSET:  offset_ff  <= csr_wdata[OFF_W-1:0];
            REG_CRUISE:  cruise_ff  <= csr_wdata[SPD_W-1:0];
            REG_TURNSPD: turnspd_ff <= csr_wdata[SPD_W-1:0];
            REG_STEP:    step_ff    <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer, profile state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tpx_ff       <= '0;
         tpy_ff       <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_CLASS && ph_sel == PH_TURN) begin
            heading_ff <= head_next;
            tpx_ff     <= x_ff;
            tpy_ff     <= y_ff;
         end
      end
   end

   // sample datapath
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= res_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               x_ff  <= req_data.pos_x_mm;
               y_ff  <= req_data.pos_y_mm;
               ls_ff <= req_data.line_status;
            end
         end
         S_DIFF: begin
            dx_ff <= dx_s[MAG_W-1] ? MAG_W'(-dx_s) : MAG_W'(dx_s);
            dy_ff <= dy_s[MAG_W-1] ? MAG_W'(-dy_s) : MAG_W'(dy_s);
         end
         S_MDY:   d2_ff   <= mul_p;
         S_MACC:  d2_ff   <= d2_ff + mul_p;
         S_MLEN:  acc2_ff <= mul_p;
         S_MDIFF: len2_ff <= mul_p;
         S_CLASS: begin
            ph_ff        <= ph_sel;
            res_ff.phase <= ph_sel;
            if (ph_sel == PH_TURN) begin
               res_ff.drive_mode  <= MODE_TURN;
               res_ff.heading_deg <= head_next;
               res_ff.speed_cmd   <= turnspd_ff;
            end else begin
               res_ff.drive_mode  <= MODE_TRACK;
               res_ff.heading_deg <= heading_ff;
               // overshoot with the line still present stops the robot
               res_ff.speed_cmd   <= (ph_sel == PH_CRUISE) ? cruise_ff : '0;
            end
         end
         S_SPEED: res_ff.speed_cmd <= spd_sat;
         default: ;
      endcase
   end

endmodule
